// ----- rtl/assert_macros.svh -----
// Assertion shorthands for the color offset / stddev threshold block.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/cost_pkg.sv -----
// Shared types and constants for the color offset / stddev threshold block.
// No dependencies.
`default_nettype none

package cost_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 65536;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned OFFSET_W  = 9;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned DIV_IDX_W = 3;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
  localparam logic [PIX_W-1:0] PIX_MIN = 8'd0;

  localparam logic signed [OFFSET_W-1:0] RED_OFFSET_RST   = 9'sd30;
  localparam logic signed [OFFSET_W-1:0] GREEN_OFFSET_RST = -9'sd20;

  localparam logic [CFG_IDX_W-1:0] REG_RED_OFFSET   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_OFFSET = 1'd1;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_EMIT  = 1'b1;

  typedef struct packed {
    logic                 acc_en;     // add accepted pixel to frame sums
    logic                 pix_en;     // capture accepted pixel for pass two
    logic                 div_load;   // seed mean divider
    logic                 div_step;   // one restoring division step
    logic [DIV_IDX_W-1:0] div_idx;    // quotient bit for this step
    logic                 dev_mult;   // form mean products
    logic                 dev_latch;  // latch statistics, clear sums
    logic                 out_load;   // load result register
  } cost_cmd_t;

  typedef struct packed {
    logic out_busy;                   // result register full and held
  } cost_stat_t;

endpackage

`default_nettype wire

// ----- rtl/cost_ctrl.sv -----
// Controller for the color offset / stddev threshold block: sequences
// accumulate, frame-end statistics and pass-two pixels. Uses cost_pkg.
`default_nettype none

module cost_ctrl
  import cost_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       opcode,
  input  wire logic       frame_end,
  output logic            in_ready,
  input  wire cost_stat_t stat,
  output cost_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_LOAD,
    S_DIV,
    S_DEV_MULT,
    S_DEV_LATCH,
    S_PIX
  } state_t;

  state_t               state;
  logic [DIV_IDX_W-1:0] cnt;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.acc_en    = in_ready && in_valid && (opcode == OP_ACCUM);
    cmd.pix_en    = in_ready && in_valid && (opcode == OP_EMIT);
    cmd.div_load  = (state == S_DIV_LOAD);
    cmd.div_step  = (state == S_DIV);
    cmd.div_idx   = cnt;
    cmd.dev_mult  = (state == S_DEV_MULT);
    cmd.dev_latch = (state == S_DEV_LATCH);
    cmd.out_load  = (state == S_PIX) && !stat.out_busy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (opcode == OP_EMIT) begin
              state <= S_PIX;
            end else if (frame_end) begin
              state <= S_DIV_LOAD;
            end
          end
        end
        S_DIV_LOAD: begin
          state <= S_DIV;
          cnt   <= '1;
        end
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_DEV_MULT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_DEV_MULT:  state <= S_DEV_LATCH;
        S_DEV_LATCH: state <= S_IDLE;
        S_PIX: begin
          // hold until the result register frees up
          if (!stat.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/cost_dp.sv -----
// Datapath for the color offset / stddev threshold block: frame sums,
// mean divider, deviation, offsets and the result register. Uses cost_pkg.
`default_nettype none

module cost_dp
  import cost_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cost_cmd_t                   cmd,
  output cost_stat_t                       stat,
  input  wire logic [PIX_W-1:0]            red_in,
  input  wire logic [PIX_W-1:0]            green_in,
  input  wire logic [PIX_W-1:0]            blue_in,
  input  wire logic                        cfg_write,
  input  wire logic [CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [OFFSET_W-1:0]         cfg_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [PIX_W-1:0]                 red_out,
  output logic [PIX_W-1:0]                 green_out,
  output logic [PIX_W-1:0]                 blue_out
);

  localparam int unsigned CW = $clog2(MAX_PIXELS + 1);  // pixel count
  localparam int unsigned SW = CW + PIX_W;              // blue sum
  localparam int unsigned QW = CW + 2 * PIX_W;          // square sums
  localparam int unsigned TW = QW + 2;                  // deviation scratch
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_PIXELS);

  // configuration
  logic signed [OFFSET_W-1:0] red_offset;
  logic signed [OFFSET_W-1:0] green_offset;

  // frame sums
  logic [CW-1:0] pixel_count;
  logic [SW-1:0] blue_sum;
  logic [QW-1:0] blue_square_sum;

  // divider and deviation scratch
  logic [SW-1:0]      rem;
  logic [PIX_W-1:0]   quot;
  logic [SW-1:0]      div_trial;
  logic [PIX_W-1:0]   mean_eff;
  logic [PIX_W-1:0]   mean_tmp;
  logic [2*PIX_W-1:0] mean_sq;
  logic [QW-1:0]      mean_sum;
  logic [QW-1:0]      cnt_mean_sq;
  logic [TW-1:0]      dev_wide;

  // latched statistics
  logic [PIX_W-1:0] mean_blue;
  logic [QW-1:0]    deviation_sum;
  logic [CW-1:0]    frame_pixels;

  // pass-two pixel stage
  logic signed [OFFSET_W:0] red_sum;
  logic signed [OFFSET_W:0] green_sum;
  logic [PIX_W-1:0]         red_clamp;
  logic [PIX_W-1:0]         green_clamp;
  logic                     blue_above;
  logic [PIX_W-1:0]         blue_dist;
  logic [PIX_W-1:0]         red_q;
  logic [PIX_W-1:0]         green_q;
  logic [PIX_W-1:0]         blue_q;
  logic                     above_q;
  logic [2*PIX_W-1:0]       dist_sq_q;
  logic [QW-1:0]            dist_prod;
  logic [PIX_W-1:0]         blue_res;

  assign stat.out_busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_offset   <= RED_OFFSET_RST;
      green_offset <= GREEN_OFFSET_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RED_OFFSET:   red_offset   <= cfg_data;
        REG_GREEN_OFFSET: green_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame-end math
  assign div_trial   = SW'(pixel_count) << cmd.div_idx;
  assign mean_eff    = (pixel_count == '0) ? PIX_MIN : quot;
  assign cnt_mean_sq = QW'(pixel_count) * QW'(mean_sq);
  assign dev_wide    = TW'(blue_square_sum) + TW'(cnt_mean_sq) - (TW'(mean_sum) << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count     <= '0;
      blue_sum        <= '0;
      blue_square_sum <= '0;
      mean_blue       <= '0;
      deviation_sum   <= '0;
      frame_pixels    <= '0;
    end else begin
      if (cmd.acc_en && (pixel_count < MAX_CNT)) begin
        pixel_count     <= pixel_count + 1'b1;
        blue_sum        <= blue_sum + SW'(blue_in);
        blue_square_sum <= blue_square_sum + QW'(blue_in * blue_in);
      end
      if (cmd.dev_latch) begin
        mean_blue       <= mean_tmp;
        deviation_sum   <= QW'(dev_wide);
        frame_pixels    <= pixel_count;
        pixel_count     <= '0;
        blue_sum        <= '0;
        blue_square_sum <= '0;
      end
    end
  end

  // restoring division: mean always fits one byte
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem  <= blue_sum;
      quot <= '0;
    end else if (cmd.div_step && (rem >= div_trial)) begin
      rem             <= rem - div_trial;
      quot[cmd.div_idx] <= 1'b1;
    end
    if (cmd.dev_mult) begin
      mean_tmp <= mean_eff;
      mean_sq  <= mean_eff * mean_eff;
      mean_sum <= QW'(mean_eff) * QW'(blue_sum);
    end
  end

  // pass two
  assign red_sum   = $signed({2'b00, red_in}) + (OFFSET_W+1)'(red_offset);
  assign green_sum = $signed({2'b00, green_in}) + (OFFSET_W+1)'(green_offset);

  always_comb begin
    if (red_sum < 0) begin
      red_clamp = PIX_MIN;
    end else if (red_sum > $signed({2'b00, PIX_MAX})) begin
      red_clamp = PIX_MAX;
    end else begin
      red_clamp = red_sum[PIX_W-1:0];
    end
    if (green_sum < 0) begin
      green_clamp = PIX_MIN;
    end else if (green_sum > $signed({2'b00, PIX_MAX})) begin
      green_clamp = PIX_MAX;
    end else begin
      green_clamp = green_sum[PIX_W-1:0];
    end
  end

  assign blue_above = blue_in > mean_blue;
  assign blue_dist  = blue_above ? (blue_in - mean_blue) : (mean_blue - blue_in);

  always_ff @(posedge clk) begin
    if (cmd.pix_en) begin
      red_q     <= red_clamp;
      green_q   <= green_clamp;
      blue_q    <= blue_in;
      above_q   <= blue_above;
      dist_sq_q <= blue_dist * blue_dist;
    end
  end

  // count*d^2 against deviation sum; d of zero never exceeds
  assign dist_prod = QW'(frame_pixels) * QW'(dist_sq_q);

  always_comb begin
    if (dist_prod > deviation_sum) begin
      blue_res = above_q ? PIX_MAX : PIX_MIN;
    end else begin
      blue_res = blue_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      red_out   <= red_q;
      green_out <= green_q;
      blue_out  <= blue_res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/color_offset_stddev_threshold_top.sv -----
// Channel   Handshake                Payload
// in        in_valid / in_ready      opcode, red_in, green_in, blue_in, frame_end
// out       out_valid / out_ready    red_out, green_out, blue_out
// cfg       cfg_write                cfg_index, cfg_data
//
// Accumulate pixels without frame_end leave the controller idle. A frame-end
// pixel runs through transfer, divider seed, 8 restoring steps of the mean divider,
// product and latch. An emit pixel runs through transfer and threshold multiply and
// waits in the latter while the result register is full and out_ready is low. The
// result register lets the next pixel transfer in while a result waits. Reset (rst,
// synchronous) clears sums and statistics and sets the offsets to 30 and -20.
// Top level of the color offset / stddev threshold block; uses cost_pkg,
// cost_ctrl, cost_dp and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module color_offset_stddev_threshold_top
  import cost_pkg::*;
#(
  parameter int unsigned MAX_PIXELS = MAX_PIXELS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 opcode,
  input  wire logic [PIX_W-1:0]     red_in,
  input  wire logic [PIX_W-1:0]     green_in,
  input  wire logic [PIX_W-1:0]     blue_in,
  input  wire logic                 frame_end,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [PIX_W-1:0]          red_out,
  output logic [PIX_W-1:0]          green_out,
  output logic [PIX_W-1:0]          blue_out,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [OFFSET_W-1:0]  cfg_data
);

  cost_cmd_t  cmd;
  cost_stat_t stat;

  cost_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .opcode    (opcode),
    .frame_end (frame_end),
    .in_ready  (in_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cost_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out)
  );

  `ASSERT_NOW(a_cmd_exclusive, clk, rst, 1'b1, $onehot0({cmd.acc_en, cmd.pix_en, cmd.div_load, cmd.div_step, cmd.dev_mult, cmd.dev_latch, cmd.out_load}))
  `ASSERT_NEXT(a_accum_one_cycle, clk, rst, in_valid && in_ready && (opcode == OP_ACCUM) && !frame_end, in_ready)
  `ASSERT_NEXT(a_frame_end_busy, clk, rst, in_valid && in_ready && (opcode == OP_ACCUM) && frame_end, !in_ready)
  `ASSERT_NEXT(a_emit_busy, clk, rst, in_valid && in_ready && (opcode == OP_EMIT), !in_ready)

endmodule

`default_nettype wire

// ----- dv/color_offset_stddev_threshold_top_tb.sv -----
// Testbench for color_offset_stddev_threshold_top: offsets, clamps and blue stddev threshold.
// Uses cost_pkg for widths, opcodes and register indexes; predicts results in a small class.
`timescale 1ns / 1ps

module color_offset_stddev_threshold_top_tb;
  import cost_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb_t;

  // Tracks offsets and frame statistics; holds the pixels that pass two must produce.
  class color_threshold_calc;
    logic signed [OFFSET_W-1:0] red_ofs;
    logic signed [OFFSET_W-1:0] green_ofs;
    longint unsigned acc_count, acc_sum, acc_sq;
    longint unsigned mean_b, dev_sum, frame_cnt;
    rgb_t expected_px[$];
    int errors;

    function new();
      red_ofs = RED_OFFSET_RST;
      green_ofs = GREEN_OFFSET_RST;
      acc_count = 0;
      acc_sum = 0;
      acc_sq = 0;
      mean_b = 0;
      dev_sum = 0;
      frame_cnt = 0;
      errors = 0;
    endfunction

    function void set_offset(logic [CFG_IDX_W-1:0] idx, logic [OFFSET_W-1:0] val);
      case (idx)
        REG_RED_OFFSET: red_ofs = val;
        REG_GREEN_OFFSET: green_ofs = val;
        default: ;
      endcase
    endfunction

    function logic [PIX_W-1:0] clamp(int v);
      if (v < 0) return PIX_MIN;
      if (v > 255) return PIX_MAX;
      return v[PIX_W-1:0];
    endfunction

    function logic [PIX_W-1:0] threshold(logic [PIX_W-1:0] b);
      longint unsigned bv, d;
      logic above;
      bv = b;
      if (bv == mean_b) return b;
      above = bv > mean_b;
      d = above ? bv - mean_b : mean_b - bv;
      if (frame_cnt * d * d > dev_sum) return above ? PIX_MAX : PIX_MIN;
      return b;
    endfunction

    function void take_pixel(logic op, logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                             logic [PIX_W-1:0] b, logic fe);
      longint unsigned bv, m;
      rgb_t px;
      bv = b;
      if (op == OP_ACCUM) begin
        // saturated count: drop the pixel but still honor frame_end
        if (acc_count < MAX_PIXELS_DEF) begin
          acc_count++;
          acc_sum += bv;
          acc_sq += bv * bv;
        end
        if (fe) begin
          if (acc_count == 0) begin
            mean_b = 0;
            dev_sum = 0;
          end else begin
            m = acc_sum / acc_count;
            mean_b = m;
            dev_sum = acc_sq + acc_count * m * m - 2 * m * acc_sum;
          end
          frame_cnt = acc_count;
          acc_count = 0;
          acc_sum = 0;
          acc_sq = 0;
        end
      end else begin
        px.red = clamp(int'(r) + int'(red_ofs));
        px.green = clamp(int'(g) + int'(green_ofs));
        px.blue = threshold(b);
        expected_px.push_back(px);
      end
    endfunction

    function void check_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
      rgb_t px;
      if (expected_px.size() == 0) begin
        $display("%0t: unexpected result red %0d green %0d blue %0d", $time, r, g, b);
        errors++;
        return;
      end
      px = expected_px.pop_front();
      if (r !== px.red) begin
        $display("%0t: red_out expected %0d, got %0d", $time, px.red, r);
        errors++;
      end
      if (g !== px.green) begin
        $display("%0t: green_out expected %0d, got %0d", $time, px.green, g);
        errors++;
      end
      if (b !== px.blue) begin
        $display("%0t: blue_out expected %0d, got %0d", $time, px.blue, b);
        errors++;
      end
    endfunction

    function int pending();
      return expected_px.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic opcode = OP_ACCUM;
  logic [PIX_W-1:0] red_in = '0;
  logic [PIX_W-1:0] green_in = '0;
  logic [PIX_W-1:0] blue_in = '0;
  logic frame_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [OFFSET_W-1:0] cfg_data = '0;

  color_threshold_calc calc;
  int idle_pct = 0;
  int stall_pct = 0;
  int pixels_sent = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  color_offset_stddev_threshold_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .frame_end (frame_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Result side: check each transfer, then decide whether to stall next cycle.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) calc.check_pixel(red_out, green_out, blue_out);
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("color_offset_stddev_threshold_top verification failed");
      $finish;
    end
  end

  function automatic logic [PIX_W-1:0] rnd8();
    return PIX_W'($urandom_range(255));
  endfunction

  function automatic logic [PIX_W-1:0] pick_blue(int center, int spread);
    int v;
    v = center + int'($urandom_range(2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PIX_W-1:0];
  endfunction

  task automatic send_pixel(input logic op, input logic [PIX_W-1:0] r,
                            input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b,
                            input logic fe);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    red_in <= r;
    green_in <= g;
    blue_in <= b;
    frame_end <= fe;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    calc.take_pixel(op, r, g, b, fe);
    pixels_sent++;
  endtask

  task automatic write_offset(input logic [CFG_IDX_W-1:0] idx, input logic [OFFSET_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    calc.set_offset(idx, val);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Drop valid, wait for every pending pixel, then let a frame-end computation finish.
  task automatic settle();
    in_valid <= 1'b0;
    while (calc.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    // no statistics yet: blue passes, red/green hit both clamps
    send_pixel(OP_EMIT, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(OP_EMIT, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(OP_EMIT, 8'd226, 8'd19, 8'd128, 1'b0);
    send_pixel(OP_EMIT, 8'd10, 8'd30, 8'd7, 1'b1);
    // frame {0, 2}: mean 1, deviation sum 2; d = 1 sits exactly on the bound
    send_pixel(OP_ACCUM, 8'd5, 8'd6, 8'd0, 1'b0);
    send_pixel(OP_ACCUM, 8'd7, 8'd8, 8'd2, 1'b1);
    send_pixel(OP_EMIT, 8'd1, 8'd21, 8'd0, 1'b0);
    send_pixel(OP_EMIT, 8'd2, 8'd20, 8'd1, 1'b0);
    send_pixel(OP_EMIT, 8'd3, 8'd19, 8'd2, 1'b0);
    send_pixel(OP_EMIT, 8'd4, 8'd18, 8'd3, 1'b0);
    send_pixel(OP_EMIT, 8'd225, 8'd254, 8'd255, 1'b0);
    // flat frame: zero deviation, any other blue is pushed to an extreme
    send_pixel(OP_ACCUM, 8'd0, 8'd0, 8'd100, 1'b0);
    send_pixel(OP_ACCUM, 8'd0, 8'd0, 8'd100, 1'b0);
    send_pixel(OP_ACCUM, 8'd0, 8'd0, 8'd100, 1'b1);
    send_pixel(OP_EMIT, 8'd40, 8'd40, 8'd100, 1'b0);
    send_pixel(OP_EMIT, 8'd40, 8'd40, 8'd101, 1'b0);
    send_pixel(OP_EMIT, 8'd40, 8'd40, 8'd99, 1'b0);
    // single-pixel frame at full blue
    send_pixel(OP_ACCUM, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(OP_EMIT, 8'd0, 8'd255, 8'd254, 1'b0);
    send_pixel(OP_EMIT, 8'd255, 8'd0, 8'd255, 1'b0);
    send_pixel(OP_EMIT, 8'd0, 8'd0, 8'd0, 1'b0);
  endtask

  task automatic run_random(input int quota);
    int stop_at, kind, n, m, i, center, spread;
    stop_at = pixels_sent + quota;
    while (pixels_sent < stop_at) begin
      kind = $urandom_range(9);
      center = $urandom_range(255);
      spread = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(6);
      if (kind < 7) begin
        // well-formed frame followed by a burst of pass-two pixels
        n = $urandom_range(12, 1);
        for (i = 1; i <= n; i++)
          send_pixel(OP_ACCUM, rnd8(), rnd8(), pick_blue(center, spread), i == n);
        m = $urandom_range(10, 1);
        for (i = 0; i < m; i++)
          send_pixel(OP_EMIT, rnd8(), rnd8(),
                     ($urandom_range(1) != 0) ? pick_blue(center, 2 * spread + 2) : rnd8(),
                     $urandom_range(3) == 0);
      end else if (kind < 9) begin
        n = $urandom_range(8, 1);
        for (i = 0; i < n; i++)
          send_pixel(1'($urandom_range(1)), rnd8(), rnd8(), rnd8(), $urandom_range(3) == 0);
      end else begin
        // open frame interrupted by pass-two pixels; a later frame_end closes it
        n = $urandom_range(6, 1);
        for (i = 0; i < n; i++)
          send_pixel(OP_ACCUM, rnd8(), rnd8(), pick_blue(center, spread), 1'b0);
        m = $urandom_range(4, 1);
        for (i = 0; i < m; i++)
          send_pixel(OP_EMIT, rnd8(), rnd8(), rnd8(), 1'b0);
      end
    end
  endtask

  initial begin
    calc = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    settle();

    write_offset(REG_RED_OFFSET, 9'h0FF);
    write_offset(REG_GREEN_OFFSET, 9'h101);
    idle_pct = 0;
    stall_pct = 0;
    run_random(125);
    settle();

    write_offset(REG_RED_OFFSET, 9'h100);
    write_offset(REG_GREEN_OFFSET, 9'h0FF);
    idle_pct = 66;
    stall_pct = 0;
    run_random(125);
    settle();

    write_offset(REG_RED_OFFSET, 9'h000);
    write_offset(REG_GREEN_OFFSET, 9'h000);
    idle_pct = 0;
    stall_pct = 66;
    run_random(125);
    settle();

    write_offset(REG_RED_OFFSET, OFFSET_W'($urandom_range(511)));
    write_offset(REG_GREEN_OFFSET, OFFSET_W'($urandom_range(511)));
    idle_pct = 38;
    stall_pct = 38;
    run_random(125);
    settle();

    if (calc.errors == 0) begin
      $display("color_offset_stddev_threshold_top verification clean");
    end else begin
      $display("color_offset_stddev_threshold_top verification failed");
    end
    $finish;
  end

endmodule

// ----- color_offset_stddev_threshold_top.f -----
+incdir+rtl
rtl/cost_pkg.sv
rtl/cost_ctrl.sv
rtl/cost_dp.sv
rtl/color_offset_stddev_threshold_top.sv
dv/color_offset_stddev_threshold_top_tb.sv
